// ----- rtl/core/nioq_pkg.sv -----
// Types and constants for the NVMe host I/O queue engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package nioq_pkg;

   // Request opcodes on the input channel
   localparam logic OPC_SUBMIT = 1'b0;
   localparam logic OPC_POLL   = 1'b1;

   // NVMe I/O command opcodes
   localparam logic [1:0] IO_OP_WRITE = 2'd1;
   localparam logic [1:0] IO_OP_READ  = 2'd2;

   // Block size limits and defaults
   localparam logic [4:0]  LG_MIN         = 5'd9;
   localparam logic [4:0]  LG_MAX         = 5'd16;
   localparam logic [23:0] POLL_LIMIT_RST = 24'd10000000;
   localparam logic [20:0] PAGE_BYTES     = 21'd4096;

   typedef enum logic [1:0] {
      KIND_SUBMIT   = 2'd0,
      KIND_DOORBELL = 2'd1,
      KIND_FINISH   = 2'd2
   } rsp_kind_type;

   typedef enum logic [1:0] {
      FIN_OK      = 2'd0,
      FIN_ERROR   = 2'd1,
      FIN_TIMEOUT = 2'd2
   } fin_status_type;

   typedef enum logic [1:0] {
      CSR_LBA_SIZE   = 2'd0,
      CSR_DMA_PAGE0  = 2'd1,
      CSR_DMA_PAGE1  = 2'd2,
      CSR_POLL_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        opcode;
      logic [63:0] start_lba;
      logic [10:0] sector_total;
      logic        write_req;
      logic [15:0] cqe_status;
   } req_type;

   typedef struct packed {
      rsp_kind_type   result_kind;
      logic [15:0]    command_id;
      logic [1:0]     io_opcode;
      logic [63:0]    slba;
      logic [3:0]     nlb_minus_one;
      logic [63:0]    prp_first;
      logic [63:0]    prp_second;
      logic [5:0]     doorbell_value;
      logic [10:0]    sectors_done;
      fin_status_type finish_status;
      logic [14:0]    error_status_field;
      logic           last;
   } rsp_type;

   // Effective configuration seen by the engine
   typedef struct packed {
      logic [4:0]  lba_size_log2;
      logic [63:0] dma_page0_addr;
      logic [63:0] dma_page1_addr;
      logic [23:0] poll_limit;
   } cfg_type;

   // Up to two results produced by one accepted item
   typedef struct packed {
      logic    push0;
      logic    push1;
      rsp_type rsp0;
      rsp_type rsp1;
   } push_type;

endpackage

`default_nettype wire

// ----- rtl/core/nioq_req_if.sv -----
// Input channel of the queue engine: valid/ready with the request payload.
// Depends on nothing but the port widths of the request fields.
`default_nettype none

interface nioq_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [63:0] start_lba;
   logic [10:0] sector_total;
   logic        write_req;
   logic [15:0] cqe_status;

   modport source (output valid, opcode, start_lba, sector_total, write_req, cqe_status,
                   input ready);
   modport sink   (input valid, opcode, start_lba, sector_total, write_req, cqe_status,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nioq_rsp_if.sv -----
// Result channel of the queue engine: valid/ready with the result payload.
// Depends on nothing but the port widths of the result fields.
`default_nettype none

interface nioq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] command_id;
   logic [1:0]  io_opcode;
   logic [63:0] slba;
   logic [3:0]  nlb_minus_one;
   logic [63:0] prp_first;
   logic [63:0] prp_second;
   logic [5:0]  doorbell_value;
   logic [10:0] sectors_done;
   logic [1:0]  finish_status;
   logic [14:0] error_status_field;
   logic        last;

   modport source (output valid, result_kind, command_id, io_opcode, slba, nlb_minus_one,
                   prp_first, prp_second, doorbell_value, sectors_done, finish_status,
                   error_status_field, last,
                   input ready);
   modport sink   (input valid, result_kind, command_id, io_opcode, slba, nlb_minus_one,
                   prp_first, prp_second, doorbell_value, sectors_done, finish_status,
                   error_status_field, last,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nioq_csr.sv -----
// Configuration registers of the queue engine and the block size clamp.
// Depends on nioq_pkg.
`default_nettype none

module nioq_csr (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_wr_en,
   input  wire  [1:0]         csr_index,
   input  wire  [63:0]        csr_wdata,
   output nioq_pkg::cfg_type  cfg
);
   import nioq_pkg::*;

   logic [4:0]  lba_size_ff;
   logic [63:0] page0_ff;
   logic [63:0] page1_ff;
   logic [23:0] poll_limit_ff;

   // Write one register per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         lba_size_ff   <= LG_MIN;
         page0_ff      <= '0;
         page1_ff      <= '0;
         poll_limit_ff <= POLL_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LBA_SIZE:   lba_size_ff   <= csr_wdata[4:0];
            CSR_DMA_PAGE0:  page0_ff      <= csr_wdata;
            CSR_DMA_PAGE1:  page1_ff      <= csr_wdata;
            CSR_POLL_LIMIT: poll_limit_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // Fall back to 512-byte blocks for an out-of-range size
   always_comb begin
      cfg.lba_size_log2  = (lba_size_ff >= LG_MIN && lba_size_ff <= LG_MAX) ? lba_size_ff
                                                                             : LG_MIN;
      cfg.dma_page0_addr = page0_ff;
      cfg.dma_page1_addr = page1_ff;
      cfg.poll_limit     = poll_limit_ff;
   end

endmodule

`default_nettype wire

// ----- rtl/core/nioq_engine.sv -----
// Queue pair state and the combinational step for one accepted request.
// Produces up to two results per transfer. Depends on nioq_pkg.
`default_nettype none

module nioq_engine #(
   parameter int RING_SLOTS          = 64,
   parameter int MAX_CHUNK_SECTORS   = 16,
   parameter int MAX_REQUEST_SECTORS = 1024
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_fire,
   input  nioq_pkg::req_type   req,
   input  nioq_pkg::cfg_type   cfg,
   output nioq_pkg::push_type  push
);
   import nioq_pkg::*;

   localparam logic [10:0] MAX_CHUNK = 11'(MAX_CHUNK_SECTORS);
   localparam logic [10:0] MAX_REQ   = 11'(MAX_REQUEST_SECTORS);
   localparam logic [6:0]  QDEPTH    = 7'(RING_SLOTS);

   logic        busy_ff,   busy_in;
   logic        wl_ff,     wl_in;
   logic        phase_ff,  phase_in;
   logic [63:0] base_ff,   base_in;
   logic [10:0] total_ff,  total_in;
   logic [10:0] done_ff,   done_in;
   logic [4:0]  chunk_ff,  chunk_in;
   logic [5:0]  tail_ff,   tail_in;
   logic [5:0]  head_ff,   head_in;
   logic [15:0] cid_ff,    cid_in;
   logic [23:0] poll_ff,   poll_in;

   logic           do_db, do_sub, do_fin;
   fin_status_type fin_status;
   logic [14:0]    fin_sf;
   logic [5:0]     head_nx, tail_nx;
   logic [23:0]    poll_nx;
   logic [10:0]    total_clamp, remain;
   logic [4:0]     chunk_sz;
   logic [20:0]    chunk_bytes;
   rsp_type        db_rsp, sub_rsp, fin_rsp;

   // Wrapped increments of the queue pointers, the poll count step and the request size clamp
   always_comb begin
      head_nx = ({1'b0, head_ff} + 7'd1 == QDEPTH) ? 6'd0 : head_ff + 6'd1;
      tail_nx = ({1'b0, tail_ff} + 7'd1 == QDEPTH) ? 6'd0 : tail_ff + 6'd1;
      poll_nx = poll_ff + 24'd1;
      total_clamp = (req.sector_total > MAX_REQ) ? MAX_REQ : req.sector_total;
   end

   // Decide the results and the next state of the queue pair
   always_comb begin
      busy_in  = busy_ff;
      wl_in    = wl_ff;
      phase_in = phase_ff;
      base_in  = base_ff;
      total_in = total_ff;
      done_in  = done_ff;
      head_in  = head_ff;
      poll_in  = poll_ff;
      do_db      = 1'b0;
      do_sub     = 1'b0;
      do_fin     = 1'b0;
      fin_status = FIN_OK;
      fin_sf     = '0;
      if (in_fire) begin
         if (req.opcode == OPC_SUBMIT) begin
            if (!busy_ff) begin
               wl_in    = req.write_req;
               base_in  = req.start_lba;
               total_in = total_clamp;
               done_in  = '0;
               poll_in  = '0;
               if (total_clamp == 11'd0) begin
                  do_fin = 1'b1;
               end else begin
                  busy_in = 1'b1;
                  do_sub  = 1'b1;
               end
            end
         end else if (busy_ff) begin
            if (req.cqe_status[0] == phase_ff) begin
               head_in = head_nx;
               if (head_nx == 6'd0) begin
                  phase_in = ~phase_ff;
               end
               do_db   = 1'b1;
               poll_in = '0;
               if (req.cqe_status[8:1] != 8'd0) begin
                  do_fin     = 1'b1;
                  fin_status = FIN_ERROR;
                  fin_sf     = req.cqe_status[15:1];
               end else begin
                  done_in = done_ff + {6'd0, chunk_ff};
                  if (done_in >= total_ff) begin
                     do_fin = 1'b1;
                  end else begin
                     do_sub = 1'b1;
                  end
               end
            end else begin
               poll_in = poll_nx;
               if (poll_nx >= cfg.poll_limit || poll_nx == 24'd0) begin
                  do_fin     = 1'b1;
                  fin_status = FIN_TIMEOUT;
               end
            end
         end
      end
      if (do_fin) begin
         busy_in = 1'b0;
         poll_in = '0;
      end
      if (do_sub) begin
         poll_in = '0;
      end
   end

   // Chunk size and the PRP2 test for the next submission entry
   always_comb begin
      remain      = total_in - done_in;
      chunk_sz    = (remain > MAX_CHUNK) ? MAX_CHUNK[4:0] : remain[4:0];
      chunk_bytes = {16'd0, chunk_sz} << cfg.lba_size_log2;
      chunk_in    = do_sub ? chunk_sz : chunk_ff;
      tail_in     = do_sub ? tail_nx : tail_ff;
      cid_in      = do_sub ? cid_ff + 16'd1 : cid_ff;
   end

   // Build the result entries
   always_comb begin
      db_rsp                = '0;
      db_rsp.result_kind    = KIND_DOORBELL;
      db_rsp.io_opcode      = wl_in ? IO_OP_WRITE : IO_OP_READ;
      db_rsp.doorbell_value = head_nx;
      db_rsp.last           = ~(do_sub | do_fin);

      sub_rsp                = '0;
      sub_rsp.result_kind    = KIND_SUBMIT;
      sub_rsp.command_id     = cid_ff;
      sub_rsp.io_opcode      = wl_in ? IO_OP_WRITE : IO_OP_READ;
      sub_rsp.slba           = base_in + {53'd0, done_in};
      sub_rsp.nlb_minus_one  = 4'(chunk_sz - 5'd1);
      sub_rsp.prp_first      = cfg.dma_page0_addr;
      sub_rsp.prp_second     = (chunk_bytes > PAGE_BYTES) ? cfg.dma_page1_addr : 64'd0;
      sub_rsp.doorbell_value = tail_nx;
      sub_rsp.last           = 1'b1;

      fin_rsp                    = '0;
      fin_rsp.result_kind        = KIND_FINISH;
      fin_rsp.io_opcode          = wl_in ? IO_OP_WRITE : IO_OP_READ;
      fin_rsp.sectors_done       = done_in;
      fin_rsp.finish_status      = fin_status;
      fin_rsp.error_status_field = fin_sf;
      fin_rsp.last               = 1'b1;

      push.push0 = do_db | do_sub | do_fin;
      push.push1 = do_db & (do_sub | do_fin);
      push.rsp0  = do_db ? db_rsp : (do_sub ? sub_rsp : fin_rsp);
      push.rsp1  = do_sub ? sub_rsp : fin_rsp;
   end

   // Hold the queue pair state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         wl_ff    <= 1'b0;
         phase_ff <= 1'b1;
         base_ff  <= '0;
         total_ff <= '0;
         done_ff  <= '0;
         chunk_ff <= '0;
         tail_ff  <= '0;
         head_ff  <= '0;
         cid_ff   <= '0;
         poll_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         wl_ff    <= wl_in;
         phase_ff <= phase_in;
         base_ff  <= base_in;
         total_ff <= total_in;
         done_ff  <= done_in;
         chunk_ff <= chunk_in;
         tail_ff  <= tail_in;
         head_ff  <= head_in;
         cid_ff   <= cid_in;
         poll_ff  <= poll_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_busy_ends_with_finish: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) && !$past(reset) |-> $past(push.push0) &&
         ($past(push.rsp0.result_kind) == KIND_FINISH ||
          $past(push.rsp1.result_kind) == KIND_FINISH))
      else $error("request ended without a finish result");

   a_second_after_doorbell: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0 && push.rsp0.result_kind == KIND_DOORBELL)
      else $error("second result without a leading doorbell");

   a_idle_poll_clear: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> poll_ff == 24'd0)
      else $error("poll count left over while idle");

   a_busy_sectors_left: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> done_ff < total_ff)
      else $error("busy with no sectors remaining");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/nioq_rsp_fifo.sv -----
// Result buffer: takes up to two results per cycle, hands out one per transfer.
// Depends on nioq_pkg.
`default_nettype none

module nioq_rsp_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  nioq_pkg::push_type  push,
   output logic                space_ok,
   output logic                out_valid,
   input  wire                 out_ready,
   output nioq_pkg::rsp_type   out_rsp
);
   import nioq_pkg::*;

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   rsp_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     count_ff,  count_in;
   logic            pop;
   logic [AW:0]     n_push;

   // Room for a full two-result item
   always_comb begin
      space_ok  = (count_ff <= (AW+1)'(DEPTH - 2));
      out_valid = (count_ff != '0);
      out_rsp   = mem_ff[rd_ptr_ff];
      pop       = out_valid & out_ready;
      n_push    = (AW+1)'(push.push0) + (AW+1)'(push.push1);
      wr_ptr_in = wr_ptr_ff + n_push[AW-1:0];
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + n_push - (AW+1)'(pop);
   end

   // Store incoming results
   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ptr_ff] <= push.rsp0;
      end
      if (push.push1) begin
         mem_ff[wr_ptr_ff + AW'(1)] <= push.rsp1;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH))
      else $error("result buffer overflow");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.push0 |-> count_ff <= (AW+1)'(DEPTH - 2))
      else $error("result pushed without room for two");

   a_empty_ptrs_meet: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("pointers apart in an empty buffer");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/nvme_io_queue_host_engine_unit.sv -----
// Host NVMe I/O queue engine: one command in flight, polled completions.
// An accepted item's results are registered in the result buffer and shown from its head.
// Throughput: one item per cycle while each item yields at most one result and the output
// is not stalled; a doorbell and a follow-up take two transfers of the one-result port.
// Reset (synchronous, active high): idle, pointers zero, phase one, registers to defaults.
// Depends on nioq_pkg, nioq_req_if, nioq_rsp_if, nioq_csr, nioq_engine, nioq_rsp_fifo.
`default_nettype none

module nvme_io_queue_host_engine_unit #(
   parameter int RING_SLOTS          = 64,
   parameter int MAX_CHUNK_SECTORS   = 16,
   parameter int MAX_REQUEST_SECTORS = 1024
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_wr_en,
   input  wire  [1:0]         csr_index,
   input  wire  [63:0]        csr_wdata,
   nioq_req_if.sink           req_chan,
   nioq_rsp_if.source         rsp_chan
);
   import nioq_pkg::*;

   cfg_type  cfg;
   req_type  req;
   push_type push;
   rsp_type  head;
   logic     space_ok;
   logic     in_fire;

   // Gather the request payload
   always_comb begin
      req.opcode       = req_chan.opcode;
      req.start_lba    = req_chan.start_lba;
      req.sector_total = req_chan.sector_total;
      req.write_req    = req_chan.write_req;
      req.cqe_status   = req_chan.cqe_status;
      req_chan.ready   = space_ok;
      in_fire          = req_chan.valid & space_ok;
   end

   nioq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nioq_engine #(
      .RING_SLOTS          (RING_SLOTS),
      .MAX_CHUNK_SECTORS   (MAX_CHUNK_SECTORS),
      .MAX_REQUEST_SECTORS (MAX_REQUEST_SECTORS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .in_fire (in_fire),
      .req     (req),
      .cfg     (cfg),
      .push    (push)
   );

   nioq_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_rsp   (head)
   );

   // Drive the result payload from the buffer head
   always_comb begin
      rsp_chan.result_kind        = head.result_kind;
      rsp_chan.command_id         = head.command_id;
      rsp_chan.io_opcode          = head.io_opcode;
      rsp_chan.slba               = head.slba;
      rsp_chan.nlb_minus_one      = head.nlb_minus_one;
      rsp_chan.prp_first          = head.prp_first;
      rsp_chan.prp_second         = head.prp_second;
      rsp_chan.doorbell_value     = head.doorbell_value;
      rsp_chan.sectors_done       = head.sectors_done;
      rsp_chan.finish_status      = head.finish_status;
      rsp_chan.error_status_field = head.error_status_field;
      rsp_chan.last               = head.last;
   end

endmodule

`default_nettype wire
